[src/cba_pkg.sv]
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types, constants and the linearization table for the contrast
// background adjuster.
// ----------------------------------------------------------------------------
`default_nettype none

package cba_pkg;

    localparam int MAX_STEPS = 40;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);

    localparam int CH_W    = 8;
    localparam int MIN_W   = 13;
    localparam int LIN_W   = 17;
    localparam int WR_W    = 28;
    localparam int WG_W    = 29;
    localparam int WB_W    = 26;
    localparam int Y_W     = 30;
    localparam int XPROD_W = 2 * Y_W;
    localparam int MPROD_W = MIN_W + Y_W;

    localparam int WT_R = 2126;
    localparam int WT_G = 7152;
    localparam int WT_B = 722;

    localparam logic [Y_W-1:0]   LUM_OFFSET  = Y_W'(32768000);
    localparam logic [MIN_W-1:0] MIN_RESET   = MIN_W'(1152);

    // reciprocal of 100 in q19, exact for dividends below 24576
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;

    localparam logic [CH_W-1:0] DARK_R  = 8'h16;
    localparam logic [CH_W-1:0] DARK_G  = 8'h18;
    localparam logic [CH_W-1:0] DARK_B  = 8'h1C;
    localparam logic [CH_W-1:0] LIGHT_C = 8'hFF;

    typedef logic [255:0][LIN_W-1:0] t_lin_rom;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_WEIGHT,
        S_SUM,
        S_PICK,
        S_DECIDE,
        S_CHECK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic look;
        logic weight;
        logic sum;
        logic pick;
        logic decide;
        logic adjust;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic below;
        logic out_valid;
    } t_status;

    function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = a * b;
        return p >> 30;
    endfunction

    function automatic logic [63:0] pow5_q30(input logic [63:0] y);
        logic [63:0] y2;
        logic [63:0] y4;
        y2 = mul_q30(y, y);
        y4 = mul_q30(y2, y2);
        return mul_q30(y4, y);
    endfunction

    // srgb code to linear light, q16, worked out at elaboration
    function automatic t_lin_rom build_lin_rom();
        t_lin_rom    rom;
        logic [63:0] n;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] v;
        for (int c = 0; c < 256; c++) begin
            if (c <= 10) begin
                v = (64'd6553600 * 64'(c) + 64'd164730) / 64'd329460;
            end else begin
                n  = 64'd1000 * 64'(c) + 64'd14025;
                t  = ((n << 30) + 64'd134512) / 64'd269025;
                t2 = mul_q30(t, t);
                lo = 64'd0;
                hi = 64'd1 << 30;
                for (int it = 0; it < 32; it++) begin
                    if (lo < hi) begin
                        mid = (lo + hi + 64'd1) >> 1;
                        if (pow5_q30(mid) <= t2) begin
                            lo = mid;
                        end else begin
                            hi = mid - 64'd1;
                        end
                    end
                end
                v = (mul_q30(t2, lo) + (64'd1 << 13)) >> 14;
            end
            rom[c] = LIN_W'(v);
        end
        return rom;
    endfunction

    localparam t_lin_rom LIN_ROM = build_lin_rom();

    function automatic logic [Y_W-1:0] lum_off(input logic [LIN_W-1:0] l_r,
                                               input logic [LIN_W-1:0] l_g,
                                               input logic [LIN_W-1:0] l_b);
        logic [63:0] s;
        s = 64'(WT_R) * 64'(l_r) + 64'(WT_G) * 64'(l_g) + 64'(WT_B) * 64'(l_b)
            + 64'(LUM_OFFSET);
        return s[Y_W-1:0];
    endfunction

    localparam logic [Y_W-1:0] Y_LIGHT_OFF =
        lum_off(LIN_ROM[LIGHT_C], LIN_ROM[LIGHT_C], LIN_ROM[LIGHT_C]);
    localparam logic [Y_W-1:0] Y_DARK_OFF =
        lum_off(LIN_ROM[DARK_R], LIN_ROM[DARK_G], LIN_ROM[DARK_B]);

endpackage

`default_nettype wire

[src/cba_datapath.sv]
// ----------------------------------------------------------------------------
// cba_datapath
// Colour registers, luminance pipeline, contrast compares, channel
// adjustment and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_datapath
    import cba_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [23:0]       i_s_tdata,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [MIN_W-1:0]  i_cfg_wr_data,
    input  wire logic              i_m_tready,
    input  wire t_cmd              i_cmd,
    output t_status                o_status,
    output logic                   o_m_tvalid,
    output logic [31:0]            o_m_tdata
);

    logic [MIN_W-1:0]   r_min;
    logic [CH_W-1:0]    r_r, r_g, r_b;
    logic [LIN_W-1:0]   r_lin_r, r_lin_g, r_lin_b;
    logic [WR_W-1:0]    r_w_r;
    logic [WG_W-1:0]    r_w_g;
    logic [WB_W-1:0]    r_w_b;
    logic [Y_W-1:0]     r_y_off;
    logic [XPROD_W-1:0] r_x_dark, r_x_light;
    logic               r_dark;
    logic               r_out_valid;
    logic [31:0]        r_out_data;

    logic [Y_W-1:0]     nd, dd, nl, dl, y_text, num, den;
    logic [MPROD_W-1:0] lhs, rhs;
    logic [CH_W-1:0]    n_r, n_g, n_b;

    function automatic logic [CH_W-1:0] adj_ch(input logic [CH_W-1:0] c, input logic dark);
        logic [14:0] x;
        logic [27:0] p;
        logic [CH_W-1:0] q;
        if (dark) begin
            x = 15'(8'd255 - c) * 15'd4 + 15'd50;
        end else begin
            x = 15'(c) * 15'd96;
        end
        p = 28'(x) * 28'(RECIP_100);
        q = p[RECIP_SHIFT +: CH_W];
        return dark ? (c + q) : q;
    endfunction

    // ratio pieces for both texts, minimum compare, adjusted channels
    always_comb begin
        nd = (r_y_off > Y_DARK_OFF)  ? r_y_off : Y_DARK_OFF;
        dd = (r_y_off > Y_DARK_OFF)  ? Y_DARK_OFF : r_y_off;
        nl = (r_y_off > Y_LIGHT_OFF) ? r_y_off : Y_LIGHT_OFF;
        dl = (r_y_off > Y_LIGHT_OFF) ? Y_LIGHT_OFF : r_y_off;
        y_text = r_dark ? Y_DARK_OFF : Y_LIGHT_OFF;
        num = (r_y_off > y_text) ? r_y_off : y_text;
        den = (r_y_off > y_text) ? y_text : r_y_off;
        lhs = {5'd0, num, 8'd0};
        rhs = MPROD_W'(r_min) * MPROD_W'(den);
        n_r = adj_ch(r_r, r_dark);
        n_g = adj_ch(r_g, r_dark);
        n_b = adj_ch(r_b, r_dark);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= MIN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_min <= i_cfg_wr_data;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_r <= i_s_tdata[7:0];
            r_g <= i_s_tdata[15:8];
            r_b <= i_s_tdata[23:16];
        end else if (i_cmd.adjust) begin
            r_r <= n_r;
            r_g <= n_g;
            r_b <= n_b;
        end
        if (i_cmd.look) begin
            r_lin_r <= LIN_ROM[r_r];
            r_lin_g <= LIN_ROM[r_g];
            r_lin_b <= LIN_ROM[r_b];
        end
        if (i_cmd.weight) begin
            r_w_r <= WR_W'(r_lin_r) * WR_W'(WT_R);
            r_w_g <= WG_W'(r_lin_g) * WG_W'(WT_G);
            r_w_b <= WB_W'(r_lin_b) * WB_W'(WT_B);
        end
        if (i_cmd.sum) begin
            r_y_off <= Y_W'(r_w_r) + Y_W'(r_w_g) + Y_W'(r_w_b) + LUM_OFFSET;
        end
        if (i_cmd.pick) begin
            r_x_dark  <= XPROD_W'(nd) * XPROD_W'(dl);
            r_x_light <= XPROD_W'(nl) * XPROD_W'(dd);
        end
        if (i_cmd.decide) begin
            // tie goes to white text
            r_dark <= r_x_dark > r_x_light;
        end
        if (i_cmd.emit) begin
            r_out_data <= {7'd0, r_dark, r_b, r_g, r_r};
        end
    end

    assign o_status.below     = lhs < rhs;
    assign o_status.out_valid = r_out_valid;
    assign o_m_tvalid         = r_out_valid;
    assign o_m_tdata          = r_out_data;

endmodule

`default_nettype wire

[src/cba_ctrl.sv]
// ----------------------------------------------------------------------------
// cba_ctrl
// Sequencer for the luminance pipeline, text choice and adjust loop.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_ctrl
    import cba_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    input  wire logic    i_m_tready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_first, n_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_first <= n_first;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_first    = r_first;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_first    = 1'b1;
                    n_state    = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = S_WEIGHT;
            end
            S_WEIGHT: begin
                o_cmd.weight = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                if (r_first) begin
                    n_state = S_PICK;
                end else if (r_step == STEP_W'(MAX_STEPS)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_first      = 1'b0;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                // contrast still short: move the colour and measure again
                if (i_status.below) begin
                    o_cmd.adjust = 1'b1;
                    n_step       = r_step + STEP_W'(1);
                    n_state      = S_LOOK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_status.out_valid || i_m_tready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/contrast_background_adjuster_unit.sv]
// ----------------------------------------------------------------------------
// contrast_background_adjuster_unit
// Picks white or graphite text for a background colour and moves the
// background until the contrast meets the programmed minimum.
// ----------------------------------------------------------------------------
// One background colour is taken per transfer and one result transfer comes
// out for it. An item first works out the background luminance and picks the
// text, then runs up to 40 lighten or darken steps (after the last step the
// compare is skipped) and finally loads the output register. Each step runs
// through the table read, the weighting multiplies, the luminance sum and the
// cross-multiplied compare in turn. A new item is accepted while the previous
// result still waits in the output register, but not while an item is in the
// loop. The minimum contrast register (q8, reset 4.5) is written through
// i_cfg_wr_en / i_cfg_wr_data; the user must write it only while the block is
// idle, which the block itself does not enforce.
`default_nettype none

module contrast_background_adjuster_unit
    import cba_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [MIN_W-1:0]  i_cfg_wr_data,   // min_contrast_q8
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [23:0]       s_tdata,         // red_in, green_in, blue_in
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata          // red_out, green_out, blue_out, dark_text
);

    t_cmd    cmd;
    t_status status;

    cba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_m_tready (m_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cba_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tdata     (s_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_m_tready    (m_tready),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_m_tvalid    (m_tvalid),
        .o_m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the contrast background adjuster. A local model
// builds its own sRGB linearization table, picks white or graphite text by
// cross-multiplied contrast ratios and replays the lighten/darken loop, then
// every result transfer is compared field by field with the oldest
// prediction. Runs directed colours, contrast minimums from zero to out of
// reach, a long output hold-off and random colours under several idle mixes.
// ----------------------------------------------------------------------------

module tb;

    import cba_pkg::CH_W;
    import cba_pkg::MIN_W;

    localparam int  ADJUST_STEPS = 40;
    localparam longint unsigned Y_OFFSET = 64'd32768000;
    localparam int  HOLD_CYCLES  = 500;
    localparam int  TAIL_CYCLES  = 180;
    localparam int  DRAIN_LIMIT  = 50000;
    localparam int  SEND_IDLE[4] = '{0, 57, 0, 33};
    localparam int  RECV_STALL[4] = '{0, 0, 57, 33};

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            dark_text;
    } t_shade;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [MIN_W-1:0]  i_cfg_wr_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [23:0]       s_tdata = '0;        // red_in, green_in, blue_in
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;             // red_out, green_out, blue_out, dark_text

    longint unsigned   linear_q16 [256];
    int unsigned       min_q8 = 1152;
    t_shade            adjusted_due [$];
    t_shade            want;
    int                mismatches = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    logic              hold_start = 1'b0;
    int                hold_left = 0;

    contrast_background_adjuster_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // local model
    // ------------------------------------------------------------------

    // linear light of one srgb code, q16
    function automatic longint unsigned srgb_to_linear(input int unsigned code);
        longint unsigned num;
        longint unsigned tq;
        longint unsigned tsq;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned p2;
        longint unsigned p4;
        longint unsigned p5;
        if (code <= 10) begin
            return (64'd6553600 * code + 64'd164730) / 64'd329460;
        end
        num = 64'd1000 * code + 64'd14025;
        tq  = ((num << 30) + 64'd134512) / 64'd269025;
        tsq = (tq * tq) >> 30;
        // largest q30 root whose truncated fifth power stays at or below t^2
        lo = 0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            p2  = (mid * mid) >> 30;
            p4  = (p2 * p2) >> 30;
            p5  = (p4 * mid) >> 30;
            if (p5 <= tsq) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return (((tsq * lo) >> 30) + 64'd8192) >> 14;
    endfunction

    // luminance plus the 0.05 flare term, units of 1/(10000*65536)
    function automatic longint unsigned lum_with_flare(input int unsigned r,
                                                       input int unsigned g,
                                                       input int unsigned b);
        return 64'd2126 * linear_q16[r] + 64'd7152 * linear_q16[g]
             + 64'd722 * linear_q16[b] + Y_OFFSET;
    endfunction

    function automatic t_shade adjust_background(input logic [7:0] r_in,
                                                 input logic [7:0] g_in,
                                                 input logic [7:0] b_in,
                                                 input int unsigned minimum);
        t_shade          res;
        int unsigned     r;
        int unsigned     g;
        int unsigned     b;
        longint unsigned y_bg;
        longint unsigned y_white;
        longint unsigned y_graphite;
        longint unsigned y_text;
        longint unsigned hi_g;
        longint unsigned lo_g;
        longint unsigned hi_w;
        longint unsigned lo_w;
        longint unsigned hi;
        longint unsigned lo;
        logic            dark;
        logic            met;
        r = r_in;
        g = g_in;
        b = b_in;
        y_white    = lum_with_flare(255, 255, 255);
        y_graphite = lum_with_flare(8'h16, 8'h18, 8'h1C);
        y_bg       = lum_with_flare(r, g, b);
        hi_g = (y_bg > y_graphite) ? y_bg : y_graphite;
        lo_g = (y_bg > y_graphite) ? y_graphite : y_bg;
        hi_w = (y_bg > y_white) ? y_bg : y_white;
        lo_w = (y_bg > y_white) ? y_white : y_bg;
        // strict compare, a tie stays with white
        dark   = (hi_g * lo_w) > (hi_w * lo_g);
        y_text = dark ? y_graphite : y_white;
        met    = 1'b0;
        for (int step = 0; step < ADJUST_STEPS && !met; step++) begin
            hi = (y_bg > y_text) ? y_bg : y_text;
            lo = (y_bg > y_text) ? y_text : y_bg;
            if (64'd256 * hi >= longint'(minimum) * lo) begin
                met = 1'b1;
            end else begin
                if (dark) begin
                    r = r + ((255 - r) * 4 + 50) / 100;
                    g = g + ((255 - g) * 4 + 50) / 100;
                    b = b + ((255 - b) * 4 + 50) / 100;
                end else begin
                    r = r * 96 / 100;
                    g = g * 96 / 100;
                    b = b * 96 / 100;
                end
                y_bg = lum_with_flare(r, g, b);
            end
        end
        res.red       = r[7:0];
        res.green     = g[7:0];
        res.blue      = b[7:0];
        res.dark_text = dark;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // receiver side and result check
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        m_tready <= !hold_start && (hold_left == 0)
                    && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (adjusted_due.size() == 0) begin
                $error("result transfer with nothing outstanding: %h", m_tdata);
                mismatches++;
            end else begin
                want = adjusted_due.pop_front();
                if (m_tdata[7:0] !== want.red) begin
                    $error("red_out: expected %0d, got %0d", want.red, m_tdata[7:0]);
                    mismatches++;
                end
                if (m_tdata[15:8] !== want.green) begin
                    $error("green_out: expected %0d, got %0d", want.green, m_tdata[15:8]);
                    mismatches++;
                end
                if (m_tdata[23:16] !== want.blue) begin
                    $error("blue_out: expected %0d, got %0d", want.blue, m_tdata[23:16]);
                    mismatches++;
                end
                if (m_tdata[24] !== want.dark_text) begin
                    $error("dark_text: expected %0d, got %0d", want.dark_text, m_tdata[24]);
                    mismatches++;
                end
                if (m_tdata[31:25] !== 7'd0) begin
                    $error("pad: expected 0, got %0h", m_tdata[31:25]);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // shared tasks
    // ------------------------------------------------------------------

    task automatic send_color(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        do @(posedge i_clk); while (s_tready !== 1'b1);
        adjusted_due.insert(adjusted_due.size(), adjust_background(r, g, b, min_q8));
    endtask

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'($urandom_range(0, 15));
            3: return 8'($urandom_range(240, 255));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_random_colors(input int count);
        for (int i = 0; i < count; i++) begin
            send_color(pick_channel(), pick_channel(), pick_channel());
        end
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (adjusted_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (adjusted_due.size() != 0) begin
            $error("results never arrived: %0d outstanding", adjusted_due.size());
            mismatches++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // only called with the block drained
    task automatic program_min_contrast(input int unsigned value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= MIN_W'(value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        min_q8 = value & 32'h1FFF;
    endtask

    task automatic set_idling(input int phase);
        send_idle_pct  = SEND_IDLE[phase];
        recv_stall_pct = RECV_STALL[phase];
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset value of the minimum, edge colours and both adjust directions
    task automatic test_directed_colors();
        set_idling(0);
        send_color(8'h00, 8'h00, 8'h00);
        send_color(8'hFF, 8'hFF, 8'hFF);
        send_color(8'hFF, 8'h00, 8'h00);
        send_color(8'h00, 8'hFF, 8'h00);
        send_color(8'h00, 8'h00, 8'hFF);
        send_color(8'h16, 8'h18, 8'h1C);
        send_color(8'h76, 8'h76, 8'h76);
        send_color(8'h77, 8'h77, 8'h77);
        send_color(8'h0A, 8'h0A, 8'h0A);
        send_color(8'h0B, 8'h0B, 8'h0B);
        send_color(8'h80, 8'h80, 8'h80);
        send_color(8'hFF, 8'hFF, 8'h00);
        send_color(8'h00, 8'hFF, 8'hFF);
        send_color(8'hFF, 8'h00, 8'hFF);
        send_color(8'h01, 8'h02, 8'h03);
        send_color(8'hFE, 8'hFD, 8'hFC);
        send_color(8'h55, 8'h55, 8'h55);
        send_color(8'hAA, 8'hAA, 8'hAA);
        send_color(8'h5A, 8'hA5, 8'h3C);
        wait_drained();
    endtask

    // a minimum at or below 1.0 lets every colour through
    task automatic test_pass_through();
        set_idling(1);
        program_min_contrast(0);
        send_random_colors(15);
        wait_drained();
        program_min_contrast(256);
        send_random_colors(15);
        wait_drained();
    endtask

    // out of reach, or met only by pure black at 21.0: items run the full step count
    task automatic test_unreachable_minimum();
        set_idling(2);
        program_min_contrast(13'h1FFF);
        send_random_colors(30);
        wait_drained();
        program_min_contrast(5376);
        send_random_colors(60);
        wait_drained();
    endtask

    // output held off long enough that the input stalls
    task automatic test_output_hold_off();
        set_idling(0);
        program_min_contrast(1152);
        hold_start <= 1'b1;
        @(posedge i_clk);
        hold_start <= 1'b0;
        send_random_colors(8);
        wait_drained();
        send_random_colors(12);
        wait_drained();
    endtask

    task automatic test_random_colors();
        for (int phase = 0; phase < 4; phase++) begin
            set_idling(phase);
            program_min_contrast(phase == 0 ? 1152 : $urandom_range(256, 5376));
            send_random_colors(100);
            wait_drained();
            program_min_contrast($urandom_range(256, 2600));
            send_random_colors(100);
            wait_drained();
        end
    endtask

    initial begin
        for (int c = 0; c < 256; c++) begin
            linear_q16[c] = srgb_to_linear(c);
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_directed_colors();
        test_pass_through();
        test_unreachable_minimum();
        test_output_hold_off();
        test_random_colors();

        if (mismatches == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule

[contrast_background_adjuster_unit.f]
src/cba_pkg.sv
src/cba_datapath.sv
src/cba_ctrl.sv
src/contrast_background_adjuster_unit.sv
tb/tb.sv
